[rtl/core/nhrt_pkg.sv]
// ----------------------------------------------------------------------------
// nhrt_pkg
// Shared widths, codes and record types for the name history ring table.
// ----------------------------------------------------------------------------
package nhrt_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int KEY_W = 64;
  localparam int CID_W = 16;
  localparam int TIME_W = 32;
  localparam int MAXC_W = 6;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 8;
  localparam int REC_W = KEY_W + TIME_W + CID_W;

  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W = OUT_DATA_W - (1 + CID_W + TIME_W + SLOT_W);

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORGET = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADDED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FORGOTTEN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END = 3'd4;

  localparam logic [MAXC_W-1:0] LIST_CAP = 6'd63;
  localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd90;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [CID_W-1:0]  cid;
    logic [TIME_W-1:0] now;
    logic [MAXC_W-1:0] maxc;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              found;
    logic [CID_W-1:0]  client;
    logic [TIME_W-1:0] logout;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] logout;
    logic [CID_W-1:0]  client;
  } rec_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] a);
    return SLOT_W'(a);
  endfunction

endpackage

[rtl/core/nhrt_ram.sv]
// ----------------------------------------------------------------------------
// nhrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nhrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/nhrt_ctrl.sv]
// ----------------------------------------------------------------------------
// nhrt_ctrl
// Command sequencer: record RAM, write pointer and fill flag, read-compare
// scan with write-back for forget, and result generation.
// ----------------------------------------------------------------------------
module nhrt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  nhrt_pkg::req_t              req,
  output logic                        ready,
  input  logic [nhrt_pkg::TIME_W-1:0] limit,
  input  logic                        out_free,
  output logic                        res_load,
  output nhrt_pkg::res_t              res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [nhrt_pkg::ADDR_W-1:0] ADDR_MAX = nhrt_pkg::ADDR_W'(nhrt_pkg::HISTORY_DEPTH - 1);
  localparam logic [nhrt_pkg::CNT_W-1:0] CNT_END = nhrt_pkg::CNT_W'(nhrt_pkg::HISTORY_DEPTH);

  logic [1:0]                        state;
  nhrt_pkg::req_t                    cmd_q;
  logic                              lk_all;
  logic [nhrt_pkg::TIME_W-1:0]       lk_thr;
  logic [nhrt_pkg::ADDR_W-1:0]       wp;
  logic                              full;
  logic [nhrt_pkg::ADDR_W-1:0]       addr;
  logic [nhrt_pkg::CNT_W-1:0]        cnt;
  logic                              rd_vld;
  logic [nhrt_pkg::ADDR_W-1:0]       rd_addr;
  logic [nhrt_pkg::MAXC_W-1:0]       n;
  logic [nhrt_pkg::MAXC_W-1:0]       lim;

  logic                              ram_we;
  logic [nhrt_pkg::ADDR_W-1:0]       ram_waddr;
  nhrt_pkg::rec_t                    ram_wdata;
  logic                              ram_re;
  nhrt_pkg::rec_t                    rec;

  logic                              rec_valid;
  logic                              key_hit;
  logic                              time_ok;
  logic                              hit;
  logic                              emits;
  logic                              stall;
  logic                              last_entry;
  logic                              scan_end;
  logic [nhrt_pkg::ADDR_W-1:0]       wp_inc;
  logic [nhrt_pkg::ADDR_W-1:0]       addr_inc;
  logic [nhrt_pkg::ADDR_W-1:0]       addr_dec;
  logic [nhrt_pkg::ADDR_W-1:0]       wp_dec;

  nhrt_ram #(
    .WIDTH (nhrt_pkg::REC_W),
    .DEPTH (nhrt_pkg::HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (rec)
  );

  assign ready      = (state == S_IDLE);
  assign wp_inc     = (wp == ADDR_MAX) ? '0 : wp + 1'b1;
  assign wp_dec     = (wp == '0) ? ADDR_MAX : wp - 1'b1;
  assign addr_inc   = (addr == ADDR_MAX) ? '0 : addr + 1'b1;
  assign addr_dec   = (addr == '0) ? ADDR_MAX : addr - 1'b1;
  assign scan_end   = (cnt == CNT_END);
  // Slots fill in order from zero, so below the pointer is valid until the ring wraps.
  assign rec_valid  = full || (rd_addr < wp);
  assign key_hit    = rec_valid && (rec.key == cmd_q.key);
  assign time_ok    = lk_all || (rec.logout >= lk_thr);
  assign last_entry = ((n + 1'b1) == lim);

  always_comb begin
    hit = 1'b0;
    case (cmd_q.cmd)
      nhrt_pkg::CMD_LOOKUP: hit = rd_vld && key_hit && time_ok;
      nhrt_pkg::CMD_LIST:   hit = rd_vld && key_hit;
      nhrt_pkg::CMD_FORGET: hit = rd_vld && rec_valid && (rec.client == cmd_q.cid);
      default:              hit = 1'b0;
    endcase
  end

  assign emits = hit && ((cmd_q.cmd == nhrt_pkg::CMD_LOOKUP) ||
                         (cmd_q.cmd == nhrt_pkg::CMD_LIST));
  assign stall = emits && !out_free;

  always_comb begin
    res_load         = 1'b0;
    res              = '0;
    ram_we           = 1'b0;
    ram_waddr        = rd_addr;
    ram_wdata.key    = rec.key;
    ram_wdata.logout = rec.logout;
    ram_wdata.client = '0;
    ram_re           = 1'b0;
    case (state)
      S_ADD: begin
        if (out_free) begin
          ram_we           = 1'b1;
          ram_waddr        = wp;
          ram_wdata.key    = cmd_q.key;
          ram_wdata.logout = cmd_q.now;
          ram_wdata.client = cmd_q.cid;
          res_load         = 1'b1;
          res.kind         = nhrt_pkg::KIND_ADDED;
          res.client       = cmd_q.cid;
          res.logout       = cmd_q.now;
          res.slot         = nhrt_pkg::slot_of(wp);
          res.last         = 1'b1;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          ram_re = !scan_end;
          if (emits) begin
            res_load   = 1'b1;
            res.found  = 1'b1;
            res.client = rec.client;
            res.logout = rec.logout;
            res.slot   = nhrt_pkg::slot_of(rd_addr);
            if (cmd_q.cmd == nhrt_pkg::CMD_LOOKUP) begin
              res.kind = nhrt_pkg::KIND_LOOKUP;
              res.last = 1'b1;
            end else begin
              res.kind = nhrt_pkg::KIND_ENTRY;
            end
          end
          if (hit && (cmd_q.cmd == nhrt_pkg::CMD_FORGET)) begin
            ram_we = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          res.last = 1'b1;
          case (cmd_q.cmd)
            nhrt_pkg::CMD_LOOKUP: res.kind = nhrt_pkg::KIND_LOOKUP;
            nhrt_pkg::CMD_FORGET: begin
              res.kind   = nhrt_pkg::KIND_FORGOTTEN;
              res.client = cmd_q.cid;
            end
            default: begin
              res.kind  = nhrt_pkg::KIND_END;
              res.found = (n != '0);
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      full   <= 1'b0;
      rd_vld <= 1'b0;
      cnt    <= '0;
      n      <= '0;
      lim    <= nhrt_pkg::LIST_CAP;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= req;
            lk_all <= (limit > req.now);
            lk_thr <= req.now - limit;
            cnt    <= '0;
            n      <= '0;
            lim    <= (req.maxc == '0) ? nhrt_pkg::LIST_CAP : req.maxc;
            case (req.cmd)
              nhrt_pkg::CMD_LIST:   addr <= wp_dec;
              nhrt_pkg::CMD_FORGET: addr <= '0;
              default:              addr <= wp;
            endcase
            state <= (req.cmd == nhrt_pkg::CMD_ADD) ? S_ADD : S_SCAN;
          end
        end
        S_ADD: begin
          if (out_free) begin
            wp <= wp_inc;
            if (wp == ADDR_MAX) begin
              full <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (emits && (cmd_q.cmd == nhrt_pkg::CMD_LOOKUP)) begin
              rd_vld <= 1'b0;
              state  <= S_IDLE;
            end else if (emits && last_entry) begin
              n      <= n + 1'b1;
              rd_vld <= 1'b0;
              state  <= S_DONE;
            end else begin
              if (emits) begin
                n <= n + 1'b1;
              end
              rd_vld <= !scan_end;
              if (!scan_end) begin
                cnt     <= cnt + 1'b1;
                rd_addr <= addr;
                addr    <= (cmd_q.cmd == nhrt_pkg::CMD_LIST) ? addr_dec : addr_inc;
              end else if (!rd_vld) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded while output register busy");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_SCAN))
    else $error("read data pending outside a scan");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_SCAN)) |-> (cmd_q.cmd == nhrt_pkg::CMD_FORGET))
    else $error("record write during a read-only scan");

  a_list_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (cmd_q.cmd == nhrt_pkg::CMD_LIST)) |-> (n < lim))
    else $error("list entry count passed its limit");

endmodule

[rtl/core/nick_history_ring_table_unit.sv]
// ----------------------------------------------------------------------------
// nick_history_ring_table_unit
// Ring of departed-name records with add, lookup, forget and list commands.
// ----------------------------------------------------------------------------
// One command is worked at a time; s_tready is high only while the sequencer
// is idle. Add writes the record and loads its result once the output register
// is free. Lookup, forget and list read the record RAM one slot per cycle, save
// while paused (one read port, registered read). A lookup stops at its first hit
// and a list at its entry limit; a lookup hit loads its result and returns to
// idle, any other scan loads its closing result from the done state. A lookup
// or list scan pauses on a hit while the output register holds an untaken
// result. No clearing pass is needed after reset: slot validity follows from
// the write pointer and a wrap flag.
module nick_history_ring_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // name_key[63:0], client_id[79:64], now_time[111:80], max_count[117:112]
  input  logic [nhrt_pkg::IN_DATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [nhrt_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // found[0], result_client[16:1], result_logout[48:17], result_slot[56:49]
  output logic [nhrt_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind[2:0]
  output logic [nhrt_pkg::KIND_W-1:0]     m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [nhrt_pkg::TIME_W-1:0]     cfg_wdata
);

  logic [nhrt_pkg::TIME_W-1:0] lookup_time_limit;
  nhrt_pkg::req_t              req;
  nhrt_pkg::res_t              res;
  nhrt_pkg::res_t              out_res;
  logic                        out_valid;
  logic                        out_free;
  logic                        res_load;
  logic                        ready;

  assign req.cmd  = s_tuser;
  assign req.key  = s_tdata[63:0];
  assign req.cid  = s_tdata[79:64];
  assign req.now  = s_tdata[111:80];
  assign req.maxc = s_tdata[117:112];

  assign s_tready = ready;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_time_limit <= nhrt_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      lookup_time_limit <= cfg_wdata;
    end
  end

  nhrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid && ready),
    .req      (req),
    .ready    (ready),
    .limit    (lookup_time_limit),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
      out_res   <= res;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {{nhrt_pkg::OUT_PAD_W{1'b0}}, out_res.slot, out_res.logout,
                     out_res.client, out_res.found};

endmodule
